@@ rtl/pose_still_checkpoint_detector_core_defines.svh @@
// Assertion macros shared by the pose still/checkpoint detector RTL.
// Needs a clk and an active-low rst_n in the scope of each use.
// Checks compile away when SYNTHESIS is defined.
`ifndef POSE_STILL_CHECKPOINT_DETECTOR_CORE_DEFINES_SVH
`define POSE_STILL_CHECKPOINT_DETECTOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PSCD_ASSERT_IMP(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
// next-cycle implication
`define PSCD_ASSERT_NXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`else
`define PSCD_ASSERT_IMP(lbl, cond, prop, msg)
`define PSCD_ASSERT_NXT(lbl, cond, prop, msg)
`endif
`endif

@@ rtl/pscd_pkg.sv @@
// Shared types and constants for the pose still/checkpoint detector.
// No dependencies; used by the channel interfaces and every module.
package pscd_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int RUN_W     = 17;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STILL_DIST = 3'd0,
        CFG_STILL_COS  = 3'd1,
        CFG_CKPT_DIST  = 3'd2,
        CFG_CKPT_COS   = 3'd3,
        CFG_RUN_LIMIT  = 3'd4
    } cfg_index_t;

    // reset values; distance limits are kept squared
    localparam logic [61:0]        STILL_DIST_SQ_RST = 62'd4356;
    localparam logic signed [31:0] STILL_COS_RST     = 32'sd1073741415;
    localparam logic [61:0]        CKPT_DIST_SQ_RST  = 62'd429496729600;
    localparam logic signed [31:0] CKPT_COS_RST      = 32'sd1037154958;
    localparam logic [15:0]        RUN_LIMIT_RST     = 16'd10;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] quat_w;
        logic signed [31:0] quat_x;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_z;
    } pose_t;

    // products of one pose pair: per-axis squared steps and quaternion terms
    typedef struct packed {
        logic [2:0]        big;  // axis step magnitude >= 2^31
        logic [2:0][61:0]  sq;
        logic [3:0][63:0]  dp;   // signed Q4.60 terms
    } pair_prod_t;

endpackage

@@ rtl/pscd_ifs.sv @@
// Channel interfaces of the pose still/checkpoint detector: pose in,
// checkpoint out, register writes. Depends on pscd_pkg.
interface pscd_pose_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;

    modport source (output valid, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
                    input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
                  output ready);
endinterface

interface pscd_mark_if;
    logic               valid;
    logic               ready;
    logic        [31:0] checkpoint_number;
    logic signed [31:0] mark_x;
    logic signed [31:0] mark_y;
    logic signed [31:0] mark_z;
    logic signed [31:0] mark_qw;
    logic signed [31:0] mark_qx;
    logic signed [31:0] mark_qy;
    logic signed [31:0] mark_qz;

    modport source (output valid, checkpoint_number, mark_x, mark_y, mark_z,
                    mark_qw, mark_qx, mark_qy, mark_qz, input ready);
    modport sink (input valid, checkpoint_number, mark_x, mark_y, mark_z,
                  mark_qw, mark_qx, mark_qy, mark_qz, output ready);
endinterface

interface pscd_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [pscd_pkg::CFG_IDX_W-1:0]     index;
    logic [31:0]                        data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/pose_still_checkpoint_detector_core.sv @@
// Top level of the pose still/checkpoint detector.
// Depends on pscd_pkg, pscd_ifs, pscd_pair_unit and the defines header.
//
//  channel      dir   beat                              notes
//  pose         in    one pose: position + quaternion   valid/ready
//  checkpoint   out   numbered checkpoint pose          valid/ready, 0 or 1 per pose
//  cfg          in    register index + write data       always ready
//
// One pose per cycle sustained while the checkpoint output is not stalled; a
// checkpoint passes the input register, product register and result register.
// The product stage uses 14 parallel 32x32 multipliers.
// rst_n clears control state and restores the register reset values at once.
// A stalled checkpoint output backs up through both stages into pose.ready.
`include "pose_still_checkpoint_detector_core_defines.svh"

module pose_still_checkpoint_detector_core
(
    input  logic      clk,
    input  logic      rst_n,
    pscd_pose_if.sink pose,
    pscd_mark_if.source checkpoint,
    pscd_cfg_if.sink  cfg
);

    // ---------------------------------------------------------------
    // Configuration. Distance limits are squared on the write so the
    // datapath only compares.
    // ---------------------------------------------------------------
    logic [61:0]        still_dist_sq_reg;
    logic signed [31:0] still_cos_reg;
    logic [61:0]        ckpt_dist_sq_reg;
    logic signed [31:0] ckpt_cos_reg;
    logic [15:0]        run_limit_reg;
    logic [61:0]        cfg_dist_sq;

    assign cfg.ready   = 1'b1;
    assign cfg_dist_sq = 62'(cfg.data[30:0]) * 62'(cfg.data[30:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            still_dist_sq_reg <= pscd_pkg::STILL_DIST_SQ_RST;
            still_cos_reg     <= pscd_pkg::STILL_COS_RST;
            ckpt_dist_sq_reg  <= pscd_pkg::CKPT_DIST_SQ_RST;
            ckpt_cos_reg      <= pscd_pkg::CKPT_COS_RST;
            run_limit_reg     <= pscd_pkg::RUN_LIMIT_RST;
        end
        else if (cfg.valid)
        begin
            unique case (pscd_pkg::cfg_index_t'(cfg.index))
                pscd_pkg::CFG_STILL_DIST: still_dist_sq_reg <= cfg_dist_sq;
                pscd_pkg::CFG_STILL_COS:  still_cos_reg     <= cfg.data;
                pscd_pkg::CFG_CKPT_DIST:  ckpt_dist_sq_reg  <= cfg_dist_sq;
                pscd_pkg::CFG_CKPT_COS:   ckpt_cos_reg      <= cfg.data;
                pscd_pkg::CFG_RUN_LIMIT:  run_limit_reg     <= cfg.data[15:0];
                default: ;  // unused indexes drop the write
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Handshake chain: input stage A -> product stage B -> result reg.
    // ---------------------------------------------------------------
    logic a_valid_reg;
    logic b_valid_reg;
    logic out_valid_reg;
    logic in_beat;
    logic a_adv;
    logic b_adv;

    assign b_adv     = b_valid_reg && (!out_valid_reg || checkpoint.ready);
    assign a_adv     = a_valid_reg && (!b_valid_reg || b_adv);
    assign pose.ready = !a_valid_reg || a_adv;
    assign in_beat   = pose.valid && pose.ready;

    // ---------------------------------------------------------------
    // Stage A: newest pose and the one before it.
    // a_cur_reg loads only on a beat, so it always holds the last pose.
    // ---------------------------------------------------------------
    pscd_pkg::pose_t in_pose;
    pscd_pkg::pose_t a_cur_reg;
    pscd_pkg::pose_t a_prev_reg;
    pscd_pkg::pose_t ckpt_reg;
    logic            seen_reg;
    logic            a_first_reg;

    always_comb
    begin
        in_pose.pos_x  = pose.pos_x;
        in_pose.pos_y  = pose.pos_y;
        in_pose.pos_z  = pose.pos_z;
        in_pose.quat_w = pose.quat_w;
        in_pose.quat_x = pose.quat_x;
        in_pose.quat_y = pose.quat_y;
        in_pose.quat_z = pose.quat_z;
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            a_cur_reg  <= in_pose;
            a_prev_reg <= a_cur_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            a_first_reg <= 1'b0;
            seen_reg    <= 1'b0;
        end
        else
        begin
            if (in_beat)
            begin
                a_valid_reg <= 1'b1;
                a_first_reg <= !seen_reg;
                seen_reg    <= 1'b1;
            end
            else if (a_adv)
            begin
                a_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Products: current pose against the previous pose, and against the
    // stored checkpoint as it stands when the pose leaves stage A.
    // ---------------------------------------------------------------
    pscd_pkg::pair_prod_t prod_prev;
    pscd_pkg::pair_prod_t prod_ckpt;

    pscd_pair_unit u_prev_pair
    (
        .clk  (clk),
        .en   (a_adv),
        .cur  (a_cur_reg),
        .base (a_prev_reg),
        .prod (prod_prev)
    );

    pscd_pair_unit u_ckpt_pair
    (
        .clk  (clk),
        .en   (a_adv),
        .cur  (a_cur_reg),
        .base (ckpt_reg),
        .prod (prod_ckpt)
    );

    // ---------------------------------------------------------------
    // Stage B: sums, limit compares and the state update.
    // If the pose just ahead in B reloaded the checkpoint, that pose is
    // this pose's previous pose, so the prev-pair products stand in for
    // the (stale) checkpoint products. b_fwd_reg marks that case.
    // ---------------------------------------------------------------
    pscd_pkg::pose_t             b_cur_reg;
    logic                        b_first_reg;
    logic                        b_fwd_reg;
    logic [pscd_pkg::RUN_W-1:0]  run_reg;
    logic [31:0]                 count_reg;
    logic [31:0]                 out_num_reg;
    pscd_pkg::pose_t             out_pose_reg;

    function automatic logic [63:0] dist_sum(pscd_pkg::pair_prod_t p);
        dist_sum = 64'(p.sq[0]) + 64'(p.sq[1]) + 64'(p.sq[2]);
    endfunction

    function automatic logic signed [65:0] dot_sum(pscd_pkg::pair_prod_t p);
        logic signed [65:0] acc;
        acc = '0;
        for (int k = 0; k < 4; k++)
        begin
            acc = acc + $signed({{2{p.dp[k][63]}}, p.dp[k]});
        end
        dot_sum = acc;
    endfunction

    logic [63:0]                 dist_prev;
    logic [63:0]                 dist_ck;
    logic signed [65:0]          dot_prev;
    logic signed [65:0]          dot_ck;
    logic signed [65:0]          still_cos_scaled;
    logic signed [65:0]          ckpt_cos_scaled;
    logic [2:0]                  ck_big;
    logic [63:0]                 dist_sel;
    logic signed [65:0]          dot_sel;
    logic                        step_still;
    logic [pscd_pkg::RUN_W-1:0]  run_inc;
    logic                        is_still;
    logic                        trigger;
    logic                        fire;       // result loads the output register
    logic                        ckpt_load;  // checkpoint pose reloads
    logic [pscd_pkg::RUN_W-1:0]  run_next;

    always_comb
    begin
        dist_prev        = dist_sum(prod_prev);
        dot_prev         = dot_sum(prod_prev);
        dist_ck          = dist_sum(prod_ckpt);
        dot_ck           = dot_sum(prod_ckpt);
        still_cos_scaled = $signed({{4{still_cos_reg[31]}}, still_cos_reg, 30'b0});
        ckpt_cos_scaled  = $signed({{4{ckpt_cos_reg[31]}}, ckpt_cos_reg, 30'b0});

        step_still = !(|prod_prev.big) && (dist_prev < 64'(still_dist_sq_reg)) &&
                     (dot_prev > still_cos_scaled);

        if (!step_still)
            run_inc = '0;
        else if (&run_reg)
            run_inc = run_reg;  // saturate
        else
            run_inc = run_reg + 1'b1;

        is_still = run_inc > pscd_pkg::RUN_W'(run_limit_reg);

        ck_big   = b_fwd_reg ? prod_prev.big : prod_ckpt.big;
        dist_sel = b_fwd_reg ? dist_prev : dist_ck;
        dot_sel  = b_fwd_reg ? dot_prev : dot_ck;

        trigger = is_still && ((|ck_big) || (dist_sel > 64'(ckpt_dist_sq_reg)) ||
                               (dot_sel < ckpt_cos_scaled));

        fire      = b_adv && !b_first_reg && trigger;
        ckpt_load = b_adv && (b_first_reg || trigger);

        if (b_first_reg)
            run_next = run_reg;  // seed pose leaves the run alone
        else if (trigger)
            run_next = '0;
        else
            run_next = run_inc;
    end

    always_ff @(posedge clk)
    begin
        if (a_adv)
        begin
            b_cur_reg <= a_cur_reg;
        end
        if (ckpt_load)
        begin
            ckpt_reg <= b_cur_reg;
        end
        if (fire)
        begin
            out_num_reg  <= count_reg;
            out_pose_reg <= b_cur_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            b_first_reg   <= 1'b0;
            b_fwd_reg     <= 1'b0;
            run_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_adv)
            begin
                b_valid_reg <= 1'b1;
                b_first_reg <= a_first_reg;
                b_fwd_reg   <= ckpt_load;
            end
            else if (b_adv)
            begin
                b_valid_reg <= 1'b0;
            end

            if (b_adv)
            begin
                run_reg <= run_next;
            end
            if (fire)
            begin
                count_reg <= count_reg + 32'd1;
            end

            if (fire)
                out_valid_reg <= 1'b1;
            else if (checkpoint.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Result channel
    // ---------------------------------------------------------------
    assign checkpoint.valid             = out_valid_reg;
    assign checkpoint.checkpoint_number = out_num_reg;
    assign checkpoint.mark_x            = out_pose_reg.pos_x;
    assign checkpoint.mark_y            = out_pose_reg.pos_y;
    assign checkpoint.mark_z            = out_pose_reg.pos_z;
    assign checkpoint.mark_qw           = out_pose_reg.quat_w;
    assign checkpoint.mark_qx           = out_pose_reg.quat_x;
    assign checkpoint.mark_qy           = out_pose_reg.quat_y;
    assign checkpoint.mark_qz           = out_pose_reg.quat_z;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `PSCD_ASSERT_NXT(a_num_is_count, fire, out_num_reg == $past(count_reg), "bad checkpoint number")
    `PSCD_ASSERT_NXT(a_run_cleared, fire, run_reg == '0, "run not cleared by a checkpoint")
    `PSCD_ASSERT_NXT(a_fwd_flag, a_adv, b_fwd_reg == $past(ckpt_load), "forward flag mismatch")
    `PSCD_ASSERT_IMP(a_seed, b_adv && b_first_reg, !fire && ckpt_load, "seed pose mishandled")

endmodule

@@ rtl/pscd_pair_unit.sv @@
// Product stage for one pose pair: axis steps squared and quaternion
// terms, registered. Depends on pscd_pkg.
module pscd_pair_unit
(
    input  logic                 clk,
    input  logic                 en,
    input  pscd_pkg::pose_t      cur,
    input  pscd_pkg::pose_t      base,
    output pscd_pkg::pair_prod_t prod
);

    logic [2:0][31:0]     cur_p;
    logic [2:0][31:0]     base_p;
    logic [3:0][31:0]     cur_q;
    logic [3:0][31:0]     base_q;
    logic [2:0][32:0]     diff;
    logic signed [63:0]   sq_full [3];
    logic signed [63:0]   dp_full [4];
    pscd_pkg::pair_prod_t prod_next;
    pscd_pkg::pair_prod_t prod_reg;

    always_comb
    begin
        cur_p  = {cur.pos_x, cur.pos_y, cur.pos_z};
        base_p = {base.pos_x, base.pos_y, base.pos_z};
        cur_q  = {cur.quat_w, cur.quat_x, cur.quat_y, cur.quat_z};
        base_q = {base.quat_w, base.quat_x, base.quat_y, base.quat_z};
        for (int i = 0; i < 3; i++)
        begin
            diff[i] = {cur_p[i][31], cur_p[i]} - {base_p[i][31], base_p[i]};
            // out of 32-bit range, or exactly -2^31
            prod_next.big[i] = (diff[i][32] ^ diff[i][31]) |
                               (diff[i][32] & diff[i][31] & ~(|diff[i][30:0]));
            sq_full[i] = $signed(diff[i][31:0]) * $signed(diff[i][31:0]);
            prod_next.sq[i] = sq_full[i][61:0];
        end
        for (int j = 0; j < 4; j++)
        begin
            dp_full[j] = $signed(base_q[j]) * $signed(cur_q[j]);
            prod_next.dp[j] = dp_full[j];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule
